FILE: design/integer_partition_counter_unit_macros.svh
// Assertion helpers for the partition counter top level.
`ifndef INTEGER_PARTITION_COUNTER_UNIT_MACROS_SVH
`define INTEGER_PARTITION_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ipc_pkg.sv
package ipc_pkg;

    // Query modes
    localparam logic [1:0] MODE_AT_MOST  = 2'd0;
    localparam logic [1:0] MODE_DISTINCT = 2'd1;
    localparam logic [1:0] MODE_EXACT    = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] total;
        logic [6:0] limit;
    } query_t;

    typedef struct packed {
        logic [31:0] count;
        logic        saturated;
    } result_t;

    // Command from the sequencer to the table datapath
    typedef struct packed {
        logic       issue;  // fetch the operands of the cell at row/col
        logic       init;   // load the trivial answer for row/col
        logic [1:0] mode;
    } step_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } seq_state_t;

endpackage

FILE: design/ipc_ram.sv
module ipc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: design/ipc_seq.sv
module ipc_seq import ipc_pkg::*; #(
    parameter int MAX_TOTAL = 127,
    localparam int IdxW = $clog2(MAX_TOTAL + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            query_valid,
    output logic            query_ready,
    input  query_t          query,
    output logic            result_valid,
    input  logic            result_ready,
    output step_ctl_t       step,
    output logic [IdxW-1:0] row,
    output logic [IdxW-1:0] col,
    output logic            out_load
);

    localparam int CmpW = (IdxW > 7) ? IdxW : 7;

    seq_state_t      state_reg, state_next;
    logic [1:0]      mode_reg, mode_next;
    logic [IdxW-1:0] t_reg, t_next;
    logic [IdxW-1:0] k_reg, k_next;
    logic [IdxW-1:0] i_reg, i_next;
    logic [IdxW-1:0] j_reg, j_next;
    logic            result_valid_reg, result_valid_next;

    logic [CmpW-1:0] total_w;
    logic [CmpW-1:0] limit_w;
    logic [IdxW-1:0] t_clamp;
    logic [IdxW-1:0] k_clamp;
    logic            trivial;
    logic            accept;

    // Clamp operands to the table size
    always_comb
    begin
        total_w = CmpW'(query.total);
        limit_w = CmpW'(query.limit);
        t_clamp = (total_w > CmpW'(MAX_TOTAL)) ? IdxW'(MAX_TOTAL) : IdxW'(total_w);
        k_clamp = (limit_w > CmpW'(MAX_TOTAL)) ? IdxW'(MAX_TOTAL) : IdxW'(limit_w);
        trivial = (query.mode == MODE_UNUSED) || (t_clamp == '0) || (k_clamp == '0);
    end

    assign query_ready  = (state_reg == S_IDLE);
    assign accept       = query_valid && query_ready;
    assign result_valid = result_valid_reg;

    // Walk the table row by row, one cell per cycle
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        step       = '0;
        row        = i_reg;
        col        = j_reg;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                row = t_clamp;
                col = k_clamp;
                if (accept)
                begin
                    mode_next = query.mode;
                    t_next    = t_clamp;
                    k_next    = k_clamp;
                    i_next    = IdxW'(1);
                    j_next    = IdxW'(1);
                    if (trivial)
                    begin
                        step.init  = 1'b1;
                        step.mode  = query.mode;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                step.issue = 1'b1;
                step.mode  = mode_reg;
                if (j_reg == k_reg)
                begin
                    j_next = IdxW'(1);
                    i_next = i_reg + IdxW'(1);
                    if (i_reg == t_reg)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    j_next = j_reg + IdxW'(1);
                end
            end
            S_LAST:
            begin
                // final cell is written back this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transaction completes
    always_comb
    begin
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        t_reg    <= t_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
    end

endmodule

FILE: design/ipc_dp.sv
module ipc_dp import ipc_pkg::*; #(
    parameter int MAX_TOTAL = 127,
    parameter int COUNT_BITS = 32,
    localparam int IdxW = $clog2(MAX_TOTAL + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  step_ctl_t             step,
    input  logic [IdxW-1:0]       row,
    input  logic [IdxW-1:0]       col,
    output logic [COUNT_BITS-1:0] res_count,
    output logic                  res_sat
);

    localparam int AddrW = 2 * IdxW;
    localparam int DataW = COUNT_BITS + 1;
    localparam int Depth = 2 ** AddrW;

    // Operand fetch (read stage)
    logic            gt, eq, j_one;
    logic [IdxW-1:0] diff, im1, jm1;
    logic            a_ram, a_one, b_ram;
    logic [IdxW-1:0] a_row, a_col, b_row, b_col;
    logic [AddrW-1:0] addr_a, addr_b, addr_w;
    logic            fwd_a, fwd_b;

    // Add stage
    logic             s2_valid_reg;
    logic [AddrW-1:0] s2_addr_reg;
    logic             s2_a_ram_reg, s2_a_one_reg, s2_a_fwd_reg;
    logic             s2_b_ram_reg, s2_b_fwd_reg;
    logic [DataW-1:0] rd_a, rd_b;
    logic [DataW-1:0] op_a, op_b;
    logic [COUNT_BITS:0] sum;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] last_reg, last_next;
    logic             init_one;

    // Choose the two cells that feed this cell
    always_comb
    begin
        gt    = row > col;
        eq    = row == col;
        diff  = row - col;
        im1   = row - IdxW'(1);
        jm1   = col - IdxW'(1);
        j_one = (jm1 == '0);
        a_ram = 1'b0;
        a_one = 1'b0;
        a_row = row;
        a_col = row;
        b_ram = 1'b0;
        b_row = row;
        b_col = jm1;

        if (step.mode == MODE_EXACT)
        begin
            if (gt)
            begin
                a_ram = 1'b1;
                a_row = diff;
                a_col = col;
                b_ram = !j_one;
                b_row = im1;
            end
            else if (eq)
            begin
                a_one = 1'b1;
            end
        end
        else
        begin
            if (gt)
            begin
                a_row = diff;
                if (step.mode == MODE_DISTINCT)
                begin
                    a_ram = !j_one;
                    a_col = jm1;
                end
                else
                begin
                    a_ram = 1'b1;
                    a_col = col;
                end
                b_ram = !j_one;
            end
            else if (eq)
            begin
                a_one = 1'b1;
                b_ram = !j_one;
            end
            else
            begin
                // copy the diagonal cell of this row
                a_ram = 1'b1;
            end
        end

        addr_a = {a_row, a_col};
        addr_b = {b_row, b_col};
        addr_w = {row, col};
        // the cell in the add stage is not in memory yet
        fwd_a  = s2_valid_reg && a_ram && (addr_a == s2_addr_reg);
        fwd_b  = s2_valid_reg && b_ram && (addr_b == s2_addr_reg);
    end

    ipc_ram #(
        .WIDTH (DataW),
        .DEPTH (Depth)
    ) u_table (
        .clk     (clk),
        .we      (s2_valid_reg),
        .waddr   (s2_addr_reg),
        .wdata   (wdata),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Advance the cell into the add stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= step.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg  <= addr_w;
        s2_a_ram_reg <= a_ram;
        s2_a_one_reg <= a_one;
        s2_a_fwd_reg <= fwd_a;
        s2_b_ram_reg <= b_ram;
        s2_b_fwd_reg <= fwd_b;
        last_reg     <= last_next;
    end

    // Saturating add; the top bit of a table word is the sticky flag
    always_comb
    begin
        if (s2_a_ram_reg)
        begin
            op_a = s2_a_fwd_reg ? last_reg : rd_a;
        end
        else
        begin
            op_a = {1'b0, COUNT_BITS'(s2_a_one_reg)};
        end
        if (s2_b_ram_reg)
        begin
            op_b = s2_b_fwd_reg ? last_reg : rd_b;
        end
        else
        begin
            op_b = '0;
        end
        sum = {1'b0, op_a[COUNT_BITS-1:0]} + {1'b0, op_b[COUNT_BITS-1:0]};
        if (sum[COUNT_BITS])
        begin
            wdata = {1'b1, {COUNT_BITS{1'b1}}};
        end
        else
        begin
            wdata = {op_a[COUNT_BITS] | op_b[COUNT_BITS], sum[COUNT_BITS-1:0]};
        end
    end

    // Keep the last written cell; it is the answer once the walk ends
    always_comb
    begin
        init_one = (step.mode == MODE_EXACT) && (row == col);
        if (step.init)
        begin
            last_next = {1'b0, COUNT_BITS'(init_one)};
        end
        else if (s2_valid_reg)
        begin
            last_next = wdata;
        end
        else
        begin
            last_next = last_reg;
        end
    end

    assign res_count = last_reg[COUNT_BITS-1:0];
    assign res_sat   = last_reg[COUNT_BITS];

endmodule

FILE: design/integer_partition_counter_unit.sv
// A nontrivial query goes through the table walk (S_RUN), S_LAST and S_DONE to the
// output register; with a zero total or limit, or in the unused mode, S_IDLE goes
// straight to S_DONE. A new query is accepted only once the last result is loaded;
// one shared adder fills one table cell per cycle through the table's single write port.
// Reset clears the sequencer, the add-stage valid and output valid only; the count table
// is not cleared, since each query rewrites every cell it later reads.
`include "integer_partition_counter_unit_macros.svh"

module integer_partition_counter_unit import ipc_pkg::*; #(
    parameter int MAX_TOTAL = 127,
    parameter int COUNT_BITS = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_ready,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int IdxW = $clog2(MAX_TOTAL + 1);

    step_ctl_t             step;
    logic [IdxW-1:0]       row;
    logic [IdxW-1:0]       col;
    logic                  out_load;
    logic [COUNT_BITS-1:0] res_count;
    logic                  res_sat;
    logic [63:0]           count_wide;
    result_t               result_reg;
    logic                  query_fire;
    logic                  result_slot_free;

    ipc_seq #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .step         (step),
        .row          (row),
        .col          (col),
        .out_load     (out_load)
    );

    ipc_dp #(
        .MAX_TOTAL  (MAX_TOTAL),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .row       (row),
        .col       (col),
        .res_count (res_count),
        .res_sat   (res_sat)
    );

    // Output register, loaded when the slot is free
    assign count_wide = 64'(res_count);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg.count     <= count_wide[31:0];
            result_reg.saturated <= res_sat;
        end
    end

    assign result = result_reg;

    // Checks
    assign query_fire       = query_valid && query_ready;
    assign result_slot_free = !result_valid || result_ready;

    `IPC_ASSERT_NOW(a_busy_not_ready, clk, rst_n, step.issue, !query_ready, "busy yet ready")
    `IPC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, query_fire, !query_ready, "still idle")
    `IPC_ASSERT_NOW(a_load_slot_free, clk, rst_n, out_load, result_slot_free, "result lost")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ipc_pkg::*;

    localparam int  DIM         = 128;
    localparam int  SMALL_SPAN  = 15;
    localparam int  RANDOM_ITEMS = 80;
    localparam int  HOLD_AT     = 30;
    localparam int  LONG_HOLD   = 600;
    localparam int  TAIL_CYCLES = 50;
    localparam longint unsigned COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    query_valid = 1'b0;
    logic    query_ready;
    query_t  query = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    query_t  query_backlog[$];
    result_t predicted_counts[$];
    int      error_count = 0;
    int      results_seen = 0;
    int      mode_seen[4] = '{default: 0};
    int      send_gap = 0;
    int      recv_wait = 0;
    bit      send_calm = 1'b0;
    bit      recv_calm = 1'b0;

    // Partition tables at full size, rebuilt per query
    longint unsigned part_cnt[0:DIM-1][0:DIM-1];
    bit              part_sat[0:DIM-1][0:DIM-1];

    integer_partition_counter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Saturating add into one table cell; the flag is sticky
    function automatic void add_into(longint unsigned a, bit sa, longint unsigned b, bit sb,
                                     int r, int c);
        if (a > COUNT_MAX - b) begin
            part_cnt[r][c] = COUNT_MAX;
            part_sat[r][c] = 1'b1;
        end else begin
            part_cnt[r][c] = a + b;
            part_sat[r][c] = sa | sb;
        end
    endfunction

    // Fill the partition table for one query and pick out the answer
    function automatic result_t partition_count(query_t q);
        int              t;
        int              k;
        longint unsigned v;
        result_t         r;
        t = q.total;
        k = q.limit;
        r = '0;
        if (q.mode == MODE_UNUSED)
            return r;
        for (int i = 0; i <= t; i++) begin
            for (int j = 0; j <= k; j++) begin
                if (q.mode == MODE_EXACT)
                    v = (i == j) ? 1 : (i < j) ? 0 : (j == 1) ? 1 : 0;
                else
                    v = (i >= 1 && j >= 1 && (i == 1 || j == 1)) ? 1 : 0;
                part_cnt[i][j] = v;
                part_sat[i][j] = 1'b0;
            end
        end
        for (int i = 1; i <= t; i++) begin
            for (int j = 1; j <= k; j++) begin
                if (q.mode == MODE_EXACT) begin
                    if (i > j)
                        add_into(part_cnt[i-j][j], part_sat[i-j][j],
                                 part_cnt[i-1][j-1], part_sat[i-1][j-1], i, j);
                end else if (i < j) begin
                    part_cnt[i][j] = part_cnt[i][i];
                    part_sat[i][j] = part_sat[i][i];
                end else if (i > j) begin
                    if (q.mode == MODE_AT_MOST)
                        add_into(part_cnt[i-j][j], part_sat[i-j][j],
                                 part_cnt[i][j-1], part_sat[i][j-1], i, j);
                    else
                        add_into(part_cnt[i-j][j-1], part_sat[i-j][j-1],
                                 part_cnt[i][j-1], part_sat[i][j-1], i, j);
                end else begin
                    add_into(part_cnt[i][j-1], part_sat[i][j-1], 1, 1'b0, i, j);
                end
            end
        end
        v = part_cnt[t][k];
        r.count = v[31:0];
        r.saturated = part_sat[t][k];
        return r;
    endfunction

    // Draw an idle count; flip between calm and busy stretches now and then
    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 7) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_query(logic [1:0] mode, int total, int limit);
        query_t q;
        q.mode = mode;
        q.total = total[6:0];
        q.limit = limit[6:0];
        query_backlog.insert(query_backlog.size(), q);
    endtask

    // Query driver: predict on each transaction, then idle or offer the next one
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            query_valid <= 1'b0;
            query <= '0;
            send_gap = 0;
        end else if (!query_valid || query_ready) begin
            if (query_valid) begin
                predicted_counts.insert(predicted_counts.size(), partition_count(query));
                mode_seen[query.mode]++;
                send_gap = draw_idle(send_calm);
            end
            if (send_gap > 0) begin
                send_gap--;
                query_valid <= 1'b0;
            end else if (query_backlog.size() != 0) begin
                query <= query_backlog.pop_front();
                query_valid <= 1'b1;
            end else begin
                query_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each transaction, then stall for a drawn count
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (result_valid && result_ready) begin
                results_seen++;
                if (predicted_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result count=%0d sat=%0b",
                                              result.count, result.saturated));
                end else begin
                    result_t want;
                    want = predicted_counts.pop_front();
                    if (result.count !== want.count)
                        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                                  results_seen, result.count, want.count));
                    if (result.saturated !== want.saturated)
                        report_mismatch($sformatf("result %0d saturated %0b, want %0b",
                                                  results_seen, result.saturated,
                                                  want.saturated));
                end
                // Hold off once for a long stretch so the block backs up
                recv_wait = (results_seen == HOLD_AT) ? LONG_HOLD : draw_idle(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                result_ready <= 1'b0;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int t;
        int k;
        logic [1:0] m;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero operands, largest operands, each recurrence branch
        @(negedge clk);
        queue_query(MODE_AT_MOST, 0, 0);
        queue_query(MODE_AT_MOST, 0, 127);
        queue_query(MODE_AT_MOST, 127, 0);
        queue_query(MODE_AT_MOST, 127, 127);
        queue_query(MODE_AT_MOST, 1, 1);
        queue_query(MODE_AT_MOST, 10, 3);
        queue_query(MODE_AT_MOST, 3, 9);
        queue_query(MODE_DISTINCT, 127, 127);
        queue_query(MODE_DISTINCT, 10, 4);
        queue_query(MODE_DISTINCT, 6, 6);
        queue_query(MODE_DISTINCT, 4, 9);
        queue_query(MODE_DISTINCT, 0, 5);
        queue_query(MODE_EXACT, 0, 0);
        queue_query(MODE_EXACT, 0, 5);
        queue_query(MODE_EXACT, 127, 0);
        queue_query(MODE_EXACT, 127, 127);
        queue_query(MODE_EXACT, 127, 10);
        queue_query(MODE_EXACT, 64, 1);
        queue_query(MODE_EXACT, 10, 20);
        queue_query(MODE_UNUSED, 127, 127);
        queue_query(MODE_UNUSED, 0, 0);

        // Pause the sender until every expected result is back
        do @(negedge clk);
        while (query_backlog.size() != 0 || query_valid || predicted_counts.size() != 0);

        // Random: mostly small tables, a few drawn up to full size
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            m = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 15) == 0) begin
                t = $urandom_range(0, 127);
                k = $urandom_range(0, 127);
            end else begin
                t = $urandom_range(0, SMALL_SPAN);
                k = $urandom_range(0, SMALL_SPAN);
            end
            queue_query(m, t, k);
        end

        // Drain, then give the block a short tail
        do @(negedge clk);
        while (query_backlog.size() != 0 || query_valid || predicted_counts.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (predicted_counts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_counts.size()));

        $display("covered %0d queries: %0d at-most, %0d distinct, %0d exact, %0d unused mode",
                 mode_seen[MODE_AT_MOST] + mode_seen[MODE_DISTINCT] + mode_seen[MODE_EXACT]
                 + mode_seen[MODE_UNUSED], mode_seen[MODE_AT_MOST],
                 mode_seen[MODE_DISTINCT], mode_seen[MODE_EXACT], mode_seen[MODE_UNUSED]);
        $display("checked %0d results with one %0d-cycle result stall, %0d mismatches",
                 results_seen, LONG_HOLD, error_count);
        if (error_count == 0)
            $display("** integer_partition_counter_unit: PASSED **");
        else
            $display("** integer_partition_counter_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("** integer_partition_counter_unit: FAILED **");
        $finish;
    end

endmodule
